@@ design/http_response_header_parser_defines.svh @@
// ----------------------------------------------------------------------------
// http_response_header_parser_defines
// Assertion macros used by the checker file of the header parser.
// ----------------------------------------------------------------------------
`ifndef HTTP_RESPONSE_HEADER_PARSER_DEFINES_SVH
`define HTTP_RESPONSE_HEADER_PARSER_DEFINES_SVH

// Clocked assertion, ignored while reset is high.
`define HRHP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define HRHP_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/hrhp_pkg.sv @@
// ----------------------------------------------------------------------------
// hrhp_pkg
// Types, character codes and character class functions of the header parser.
// ----------------------------------------------------------------------------
`default_nettype none

package hrhp_pkg;

  // Verdict codes reported with every word
  typedef enum logic [1:0] {
    VERD_CONT = 2'd0,
    VERD_PASS = 2'd1,
    VERD_FAIL = 2'd2
  } verdict_t;

  // Parse phases, one-hot
  typedef enum logic [20:0] {
    PH_VER_H       = 21'h000001,
    PH_VER_T1      = 21'h000002,
    PH_VER_T2      = 21'h000004,
    PH_VER_P       = 21'h000008,
    PH_VER_SLASH   = 21'h000010,
    PH_VER_MAJOR   = 21'h000020,
    PH_VER_DOT     = 21'h000040,
    PH_VER_MINOR   = 21'h000080,
    PH_SP1         = 21'h000100,
    PH_CODE0       = 21'h000200,
    PH_CODE1       = 21'h000400,
    PH_CODE2       = 21'h000800,
    PH_SP2         = 21'h001000,
    PH_REASON      = 21'h002000,
    PH_STATUS_LF   = 21'h004000,
    PH_FIELD_LINE  = 21'h008000,
    PH_FIELD_NAME  = 21'h010000,
    PH_FIELD_VALUE = 21'h020000,
    PH_VALUE_OWS   = 21'h040000,
    PH_FIELD_LF    = 21'h080000,
    PH_END_LF      = 21'h100000
  } phase_t;

  // Content-length value scan state
  typedef enum logic [1:0] {
    VS_LEAD   = 2'd0,
    VS_DIGITS = 2'd1,
    VS_TRAIL  = 2'd2,
    VS_BAD    = 2'd3
  } vstate_t;

  // Control from the phase tracker to the value scanner
  typedef struct packed {
    logic consume;     // word is parsed (no verdict reached yet)
    logic open;        // colon seen: a field value begins
    logic is_length;   // the field name was content-length
    logic value_byte;  // word is a legal field value byte
    logic close;       // CR ends the field value
  } hrhp_ctrl_t;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_HTAB  = 8'h09;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_CTL_MAX = 8'd31;
  localparam logic [7:0] CH_DEL   = 8'd127;

  localparam logic [3:0] NAME_LEN = 4'd14;
  localparam logic [3:0] NAME_POS_MAX = 4'd15;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SP) || (c == CH_HTAB);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_token(input logic [7:0] c);
    logic sym;
    case (c)
      8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2A, 8'h2B,
      8'h2D, 8'h2E, 8'h5E, 8'h5F, 8'h60, 8'h7C, 8'h7E: sym = 1'b1;
      default: sym = 1'b0;
    endcase
    return is_digit(c) || is_alpha(c) || sym;
  endfunction

  function automatic logic is_value(input logic [7:0] c);
    return ((c >= 8'h21) && (c <= 8'h7E)) || c[7];
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) ? (c + 8'd32) : c;
  endfunction

  // Lower-case letters of "content-length"
  function automatic logic [7:0] name_char(input logic [3:0] pos);
    logic [7:0] ch;
    case (pos)
      4'd0:  ch = 8'h63; // c
      4'd1:  ch = 8'h6F; // o
      4'd2:  ch = 8'h6E; // n
      4'd3:  ch = 8'h74; // t
      4'd4:  ch = 8'h65; // e
      4'd5:  ch = 8'h6E; // n
      4'd6:  ch = 8'h74; // t
      4'd7:  ch = 8'h2D; // -
      4'd8:  ch = 8'h6C; // l
      4'd9:  ch = 8'h65; // e
      4'd10: ch = 8'h6E; // n
      4'd11: ch = 8'h67; // g
      4'd12: ch = 8'h74; // t
      4'd13: ch = 8'h68; // h
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

@@ design/hrhp_phase.sv @@
// ----------------------------------------------------------------------------
// hrhp_phase
// Syntax tracker: status line, field lines, name matching and the verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module hrhp_phase import hrhp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic       start,
  input  logic [7:0] byte_in,
  output hrhp_ctrl_t ctrl,
  output verdict_t   verdict
);

  phase_t     phase, phase_next, cur_phase;
  logic [3:0] name_pos, name_pos_next, cur_name_pos;
  logic       name_mis, name_mis_next, cur_name_mis;
  verdict_t   final_verdict, final_verdict_next, cur_verdict;

  logic [7:0] lc;
  logic       name_hit;
  logic       first_hit;
  logic [3:0] pos_inc;
  verdict_t   res;

  // start clears the state before this word is parsed
  assign cur_phase    = start ? PH_VER_H  : phase;
  assign cur_name_pos = start ? 4'd0      : name_pos;
  assign cur_name_mis = start ? 1'b0      : name_mis;
  assign cur_verdict  = start ? VERD_CONT : final_verdict;

  // case-insensitive compare against the content-length name
  assign lc        = to_lower(byte_in);
  assign name_hit  = (cur_name_pos < NAME_LEN) && (name_char(cur_name_pos) == lc);
  assign first_hit = (name_char(4'd0) == lc);
  assign pos_inc   = (cur_name_pos == NAME_POS_MAX) ? cur_name_pos : cur_name_pos + 4'd1;

  // next state and control for one word
  always_comb begin
    phase_next         = cur_phase;
    name_pos_next      = cur_name_pos;
    name_mis_next      = cur_name_mis;
    final_verdict_next = cur_verdict;
    ctrl               = '0;
    res                = VERD_CONT;
    if (cur_verdict == VERD_CONT) begin
      ctrl.consume = 1'b1;
      case (cur_phase)
        PH_VER_H:     if (byte_in == CH_H) phase_next = PH_VER_T1; else res = VERD_FAIL;
        PH_VER_T1:    if (byte_in == CH_T) phase_next = PH_VER_T2; else res = VERD_FAIL;
        PH_VER_T2:    if (byte_in == CH_T) phase_next = PH_VER_P; else res = VERD_FAIL;
        PH_VER_P:     if (byte_in == CH_P) phase_next = PH_VER_SLASH; else res = VERD_FAIL;
        PH_VER_SLASH: begin
          if (byte_in == CH_SLASH) phase_next = PH_VER_MAJOR; else res = VERD_FAIL;
        end
        PH_VER_MAJOR: begin
          if (is_digit(byte_in)) phase_next = PH_VER_DOT; else res = VERD_FAIL;
        end
        PH_VER_DOT:   if (byte_in == CH_DOT) phase_next = PH_VER_MINOR; else res = VERD_FAIL;
        PH_VER_MINOR: if (is_digit(byte_in)) phase_next = PH_SP1; else res = VERD_FAIL;
        PH_SP1:       if (byte_in == CH_SP) phase_next = PH_CODE0; else res = VERD_FAIL;
        PH_CODE0:     if (is_digit(byte_in)) phase_next = PH_CODE1; else res = VERD_FAIL;
        PH_CODE1:     if (is_digit(byte_in)) phase_next = PH_CODE2; else res = VERD_FAIL;
        PH_CODE2:     if (is_digit(byte_in)) phase_next = PH_SP2; else res = VERD_FAIL;
        PH_SP2:       if (byte_in == CH_SP) phase_next = PH_REASON; else res = VERD_FAIL;
        PH_REASON: begin
          if (byte_in == CH_CR) begin
            phase_next = PH_STATUS_LF;
          end else if ((byte_in <= CH_CTL_MAX) || (byte_in == CH_DEL)) begin
            res = VERD_FAIL;
          end
        end
        PH_STATUS_LF, PH_FIELD_LF: begin
          if (byte_in == CH_LF) phase_next = PH_FIELD_LINE; else res = VERD_FAIL;
        end
        PH_FIELD_LINE: begin
          if (byte_in == CH_CR) begin
            phase_next = PH_END_LF;
          end else if (is_token(byte_in)) begin
            name_pos_next = 4'd1;
            name_mis_next = !first_hit;
            phase_next    = PH_FIELD_NAME;
          end else begin
            res = VERD_FAIL;
          end
        end
        PH_FIELD_NAME: begin
          if (byte_in == CH_COLON) begin
            ctrl.open      = 1'b1;
            ctrl.is_length = !cur_name_mis && (cur_name_pos == NAME_LEN);
            phase_next     = PH_FIELD_VALUE;
          end else if (is_token(byte_in)) begin
            name_pos_next = pos_inc;
            name_mis_next = cur_name_mis | !name_hit;
          end else begin
            res = VERD_FAIL;
          end
        end
        PH_FIELD_VALUE, PH_VALUE_OWS: begin
          if (byte_in == CH_CR) begin
            ctrl.close = 1'b1;
            phase_next = PH_FIELD_LF;
          end else if (is_value(byte_in)) begin
            ctrl.value_byte = 1'b1;
            phase_next      = PH_FIELD_VALUE;
          end else if (is_blank(byte_in)) begin
            ctrl.value_byte = 1'b1;
            phase_next      = PH_VALUE_OWS;
          end else begin
            res = VERD_FAIL;
          end
        end
        PH_END_LF: res = (byte_in == CH_LF) ? VERD_PASS : VERD_FAIL;
        default:   res = VERD_FAIL;
      endcase
      final_verdict_next = res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_VER_H;
      name_pos      <= 4'd0;
      name_mis      <= 1'b0;
      final_verdict <= VERD_CONT;
    end else if (step) begin
      phase         <= phase_next;
      name_pos      <= name_pos_next;
      name_mis      <= name_mis_next;
      final_verdict <= final_verdict_next;
    end
  end

  assign verdict = final_verdict;

endmodule

`default_nettype wire

@@ design/hrhp_value.sv @@
// ----------------------------------------------------------------------------
// hrhp_value
// Content-length value scanner: trims blanks, accumulates decimal digits.
// ----------------------------------------------------------------------------
`default_nettype none

module hrhp_value import hrhp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  logic        start,
  input  logic [7:0]  byte_in,
  input  hrhp_ctrl_t  ctrl,
  output logic [63:0] content_length,
  output logic        length_found
);

  logic        in_len, in_len_next, cur_in_len;
  logic [63:0] acc, acc_next, cur_acc;
  vstate_t     vstate, vstate_next, cur_vstate;
  logic [63:0] len_value, len_value_next, cur_len_value;
  logic        len_valid, len_valid_next, cur_len_valid;

  logic [67:0] mac;
  logic [63:0] acc_step;

  assign cur_in_len    = start ? 1'b0    : in_len;
  assign cur_acc       = start ? '0      : acc;
  assign cur_vstate    = start ? VS_LEAD : vstate;
  assign cur_len_value = start ? '0      : len_value;
  assign cur_len_valid = start ? 1'b0    : len_valid;

  // acc * 10 + digit, saturating at all ones
  assign mac      = {1'b0, cur_acc, 3'b000} + {3'b000, cur_acc, 1'b0}
                    + {64'd0, byte_in[3:0]};
  assign acc_step = (|mac[67:64]) ? '1 : mac[63:0];

  always_comb begin
    in_len_next    = cur_in_len;
    acc_next       = cur_acc;
    vstate_next    = cur_vstate;
    len_value_next = cur_len_value;
    len_valid_next = cur_len_valid;
    // colon: new value begins
    if (ctrl.open) begin
      in_len_next = ctrl.is_length;
      acc_next    = '0;
      vstate_next = VS_LEAD;
    end
    // value word of a content-length field
    if (ctrl.value_byte && cur_in_len) begin
      if (is_blank(byte_in)) begin
        if (cur_vstate == VS_DIGITS) vstate_next = VS_TRAIL;
      end else if (is_digit(byte_in) &&
                   ((cur_vstate == VS_LEAD) || (cur_vstate == VS_DIGITS))) begin
        acc_next    = acc_step;
        vstate_next = VS_DIGITS;
      end else begin
        vstate_next = VS_BAD;
      end
    end
    // CR: keep the value if it held digits only
    if (ctrl.close) begin
      if (cur_in_len && ((cur_vstate == VS_DIGITS) || (cur_vstate == VS_TRAIL))) begin
        len_value_next = cur_acc;
        len_valid_next = 1'b1;
      end
      in_len_next = 1'b0;
      acc_next    = '0;
      vstate_next = VS_LEAD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_len    <= 1'b0;
      acc       <= '0;
      vstate    <= VS_LEAD;
      len_value <= '0;
      len_valid <= 1'b0;
    end else if (step) begin
      in_len    <= in_len_next;
      acc       <= acc_next;
      vstate    <= vstate_next;
      len_value <= len_value_next;
      len_valid <= len_valid_next;
    end
  end

  assign content_length = len_value;
  assign length_found   = len_valid;

endmodule

`default_nettype wire

@@ design/http_response_header_parser.sv @@
// An accepted word is held in the input register; its result word is registered in the parse state when it is parsed.
// Throughput: one word per cycle while the output is not stalled; the only loop is the parse state update.
// The input stage stalls only while a result word is held by a stalled output.
// Reset (rst, synchronous) clears all parse state, the counters and both valids;
// start_req clears the parse state ahead of the word that carries it.
// ----------------------------------------------------------------------------
// http_response_header_parser
// One-byte-per-word HTTP/d.d response header checker with content-length (any single-digit version).
// ----------------------------------------------------------------------------
`default_nettype none

module http_response_header_parser import hrhp_pkg::*; #(
  parameter int COUNT_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        start_req,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  verdict,
  output logic [31:0] header_length,
  output logic [63:0] content_length,
  output logic        length_found
);

  logic                  s1_valid;
  logic [7:0]            s1_byte;
  logic                  s1_start;
  logic                  step;
  logic                  in_accept;
  hrhp_ctrl_t            ctrl;
  verdict_t              phase_verdict;
  logic [COUNT_BITS-1:0] byte_count, byte_count_next, cur_count;

  // handshake: parse when the result register is free
  assign step      = s1_valid && (!out_valid || !out_stall);
  assign in_stall  = s1_valid && !step;
  assign in_accept = in_valid && !in_stall;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (step) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_byte  <= data_byte;
      s1_start <= start_req;
    end
  end

  hrhp_phase u_phase (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .start   (s1_start),
    .byte_in (s1_byte),
    .ctrl    (ctrl),
    .verdict (phase_verdict)
  );

  hrhp_value u_value (
    .clk            (clk),
    .rst            (rst),
    .step           (step),
    .start          (s1_start),
    .byte_in        (s1_byte),
    .ctrl           (ctrl),
    .content_length (content_length),
    .length_found   (length_found)
  );

  // byte counter, saturating; frozen once a verdict is reached
  assign cur_count = s1_start ? '0 : byte_count;
  always_comb begin
    byte_count_next = cur_count;
    if (ctrl.consume && !(&cur_count)) byte_count_next = cur_count + COUNT_BITS'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
    end else if (step) begin
      byte_count <= byte_count_next;
    end
  end

  // result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // header_length saturates at 32 bits
  generate
    if (COUNT_BITS > 32) begin : g_len_sat
      assign header_length = (|byte_count[COUNT_BITS-1:32]) ? '1 : byte_count[31:0];
    end else begin : g_len_ext
      assign header_length = 32'(byte_count);
    end
  endgenerate

  assign verdict = phase_verdict;

endmodule

`default_nettype wire

@@ design/hrhp_checker.sv @@
// ----------------------------------------------------------------------------
// hrhp_checker
// Port-level checks of the header parser, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "http_response_header_parser_defines.svh"

module hrhp_checker import hrhp_pkg::*; (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic [7:0]  data_byte,
  input wire logic        start_req,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [1:0]  verdict,
  input wire logic [31:0] header_length,
  input wire logic [63:0] content_length,
  input wire logic        length_found
);

  // a stalled result word holds
  `HRHP_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(verdict) && $stable(header_length) && $stable(content_length) && $stable(length_found), "result word changed while stalled")

  // a stalled input word holds
  `HRHP_ASSERT(a_in_hold, in_valid && in_stall |=> in_valid && $stable(data_byte) && $stable(start_req), "input word moved while stalled")

  // input only backs up behind a stalled result
  `HRHP_ASSERT_ALWAYS(a_stall_cause, in_stall |-> (out_valid && out_stall), "input stalled without output backpressure")

  // no length value without a valid content-length field
  `HRHP_ASSERT(a_len_found, out_valid && !length_found |-> content_length == 64'd0, "content_length set while length_found low")

  // shortest complete header is 17 bytes
  `HRHP_ASSERT(a_pass_len, out_valid && (verdict == VERD_PASS) |-> header_length >= 32'd17, "pass verdict on a too short header")

endmodule

bind http_response_header_parser hrhp_checker u_hrhp_checker (.*);

`default_nettype wire
